@@ rtl/sws_pkg.sv @@
`default_nettype none

package sws_pkg;

  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned MAX_BODY   = 1456;

  localparam int unsigned SLOT_W = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned WIN_W  = 7;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HANDSHAKE_SEQ = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_SIZE_RST   = 7'd16;
  localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST = 16'd500;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_ACK   = 2'd2,
    MODE_END   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SEND   = 2'd1,
    ACT_REFUSE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PKT_START = 2'd0,
    PKT_END   = 2'd1,
    PKT_DATA  = 2'd2
  } pkt_type_e;

  typedef enum logic [1:0] {
    PH_OPEN  = 2'd0,
    PH_XFER  = 2'd1,
    PH_CLOSE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [WORD_W-1:0] checksum;
  } sws_desc_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              desc_we;
    logic              time_we;
    logic [SLOT_W-1:0] wr_addr;
    sws_desc_t         wr_desc;
    logic [WORD_W-1:0] wr_time;
  } sws_mem_req_t;

  typedef struct packed {
    sws_desc_t         desc;
    logic [WORD_W-1:0] sent_time;
  } sws_mem_rsp_t;

endpackage

`default_nettype wire

@@ rtl/sws_store.sv @@
`default_nettype none

module sws_store
  import sws_pkg::*;
(
  input  wire logic         clk_i,
  input  wire sws_mem_req_t req_i,
  output sws_mem_rsp_t      rsp_o
);

  sws_desc_t         desc_mem [WINDOW_MAX];
  logic [WORD_W-1:0] time_mem [WINDOW_MAX];
  sws_mem_rsp_t      rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.desc_we) begin
      desc_mem[req_i.wr_addr] <= req_i.wr_desc;
    end
    if (req_i.time_we) begin
      time_mem[req_i.wr_addr] <= req_i.wr_time;
    end
    if (req_i.rd_en) begin
      rsp_q.desc      <= desc_mem[req_i.rd_addr];
      rsp_q.sent_time <= time_mem[req_i.rd_addr];
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

@@ rtl/sliding_window_sender_unit.sv @@
// Sliding window sender: transmit side of a go-back-N transport with
// cumulative acks. One input transaction carries a millisecond tick, a data
// offer, a received ack or the end of the source; each one yields exactly
// one result transaction describing what to send (START, END or DATA,
// first send or resend), a refusal, or nothing, plus phase and in-flight
// count after the step.
// Both channels use valid/stall; configuration uses a plain write port
// (cfg_we_i, cfg_index_i, cfg_data_i) and must be written while idle.
// Timing: the accept cycle reads the head slot of the descriptor and
// send-time memories; in the execute state that follows, once the output
// register is free, the block computes, writes back the slot and loads the
// output register. The input stalls in the execute state, so a new
// transaction is taken only after the last one has been written back to the
// slot memories. One transaction may be accepted while a result waits;
// while the receiver stalls, it is held until the output register frees.
// Reset puts the block in the opening phase with an empty window and the
// registers at window 16, timeout 500, handshake sequence 0. The slot
// memories need no clearing: only slots inside the window are used.
`default_nettype none

module sliding_window_sender_unit
  import sws_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [WORD_W-1:0] cfg_data_i,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [LEN_W-1:0]  offer_length_i,
  input  wire logic [WORD_W-1:0] offer_checksum_i,
  input  wire logic [WORD_W-1:0] ack_seq_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             action_o,
  output logic [1:0]             pkt_type_o,
  output logic [WORD_W-1:0]      seq_out_o,
  output logic [LEN_W-1:0]       length_out_o,
  output logic [WORD_W-1:0]      checksum_out_o,
  output logic [SLOT_W-1:0]      slot_out_o,
  output logic                   is_resend_o,
  output logic [CNT_W-1:0]       freed_count_o,
  output logic [1:0]             phase_out_o,
  output logic [CNT_W-1:0]       in_flight_o
);

  logic [WIN_W-1:0]  window_size_q;
  logic [TMO_W-1:0]  timeout_q;
  logic [WORD_W-1:0] hs_seq_q;

  ctl_state_e state_q, state_d;
  logic       accept;
  logic       out_free;
  logic       commit;

  logic [1:0]        mode_q;
  logic [LEN_W-1:0]  len_q;
  logic [WORD_W-1:0] crc_q;
  logic [WORD_W-1:0] ack_q;

  phase_e            phase_q, phase_d;
  logic              hs_sent_q, hs_sent_d;
  logic [WORD_W-1:0] hs_time_q, hs_time_d;
  logic [WORD_W-1:0] now_q, now_d;
  logic [WORD_W-1:0] base_q, base_d;
  logic [WORD_W-1:0] next_q, next_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  wc_q, wc_d;
  logic              src_done_q, src_done_d;

  sws_mem_req_t mem_req;
  sws_mem_rsp_t mem_rsp;

  logic              res_valid_q;
  action_e           res_action_q, res_action_d;
  pkt_type_e         res_type_q, res_type_d;
  logic [WORD_W-1:0] res_seq_q, res_seq_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [WORD_W-1:0] res_crc_q, res_crc_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_resend_q, res_resend_d;
  logic [CNT_W-1:0]  res_freed_q, res_freed_d;
  logic [1:0]        res_phase_q;
  logic [CNT_W-1:0]  res_flight_q;

  logic [WORD_W-1:0] now_tick;
  logic [WORD_W-1:0] hs_elapsed;
  logic [WORD_W-1:0] data_elapsed;
  logic [WIN_W-1:0]  eff_win;
  logic [SLOT_W-1:0] tail_slot;
  logic [LEN_W-1:0]  len_sat;
  logic [WORD_W-1:0] ack_dist;
  logic [CNT_W-1:0]  freed;
  logic              close_now;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
      timeout_q     <= TIMEOUT_TICKS_RST;
      hs_seq_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_SIZE:   window_size_q <= cfg_data_i[WIN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_q     <= cfg_data_i[TMO_W-1:0];
        CFG_HANDSHAKE_SEQ: hs_seq_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  assign out_free = !res_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (in_valid_i) state_d = CS_EXEC;
      CS_EXEC: if (out_free)   state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      CS_EXEC: commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      len_q  <= offer_length_i;
      crc_q  <= offer_checksum_i;
      ack_q  <= ack_seq_i;
    end
  end

  sws_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  // step datapath
  assign now_tick     = now_q + 32'd1;
  assign hs_elapsed   = now_tick - hs_time_q;
  assign data_elapsed = now_tick - mem_rsp.sent_time;
  assign tail_slot    = head_q + wc_q[SLOT_W-1:0];
  assign len_sat      = (len_q > LEN_W'(MAX_BODY)) ? LEN_W'(MAX_BODY) : len_q;
  assign ack_dist     = ack_q - base_q;
  assign freed        = (ack_dist < WORD_W'(wc_q)) ? ack_dist[CNT_W-1:0] : wc_q;

  always_comb begin
    priority if (window_size_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_size_q > WIN_W'(WINDOW_MAX)) begin
      eff_win = WIN_W'(WINDOW_MAX);
    end else begin
      eff_win = window_size_q;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    hs_sent_d    = hs_sent_q;
    hs_time_d    = hs_time_q;
    now_d        = now_q;
    base_d       = base_q;
    next_d       = next_q;
    head_d       = head_q;
    wc_d         = wc_q;
    src_done_d   = src_done_q;
    close_now    = 1'b0;
    res_action_d = ACT_NONE;
    res_type_d   = PKT_START;
    res_seq_d    = '0;
    res_len_d    = '0;
    res_crc_d    = '0;
    res_slot_d   = '0;
    res_resend_d = 1'b0;
    res_freed_d  = '0;

    mem_req         = '0;
    mem_req.rd_en   = accept;
    mem_req.rd_addr = head_q;
    mem_req.wr_time = now_tick;

    unique case (mode_q)
      MODE_TICK: begin
        now_d = now_tick;
        if (phase_q == PH_OPEN || phase_q == PH_CLOSE) begin
          if (!hs_sent_q || hs_elapsed > WORD_W'(timeout_q)) begin
            res_action_d = ACT_SEND;
            res_type_d   = (phase_q == PH_OPEN) ? PKT_START : PKT_END;
            res_seq_d    = hs_seq_q;
            res_resend_d = hs_sent_q;
            hs_sent_d    = 1'b1;
            hs_time_d    = now_tick;
          end
        end else if (phase_q == PH_XFER && wc_q != '0) begin
          if (data_elapsed > WORD_W'(timeout_q)) begin
            res_action_d    = ACT_SEND;
            res_type_d      = PKT_DATA;
            res_seq_d       = base_q;
            res_len_d       = mem_rsp.desc.length;
            res_crc_d       = mem_rsp.desc.checksum;
            res_slot_d      = head_q;
            res_resend_d    = 1'b1;
            mem_req.time_we = commit;
            mem_req.wr_addr = head_q;
          end
        end
      end
      MODE_OFFER: begin
        if (phase_q == PH_XFER && !src_done_q && wc_q < CNT_W'(eff_win)) begin
          mem_req.desc_we          = commit;
          mem_req.time_we          = commit;
          mem_req.wr_addr          = tail_slot;
          mem_req.wr_desc.length   = len_sat;
          mem_req.wr_desc.checksum = crc_q;
          mem_req.wr_time          = now_q;
          res_action_d = ACT_SEND;
          res_type_d   = PKT_DATA;
          res_seq_d    = next_q;
          res_len_d    = len_sat;
          res_crc_d    = crc_q;
          res_slot_d   = tail_slot;
          next_d       = next_q + 32'd1;
          wc_d         = wc_q + CNT_W'(1);
        end else begin
          res_action_d = ACT_REFUSE;
        end
      end
      MODE_ACK: begin
        if (phase_q == PH_OPEN || phase_q == PH_CLOSE) begin
          if (hs_sent_q && ack_q == hs_seq_q) begin
            phase_d   = (phase_q == PH_OPEN) ? PH_XFER : PH_DONE;
            hs_sent_d = 1'b0;
            close_now = (phase_q == PH_OPEN);
          end
        end else if (phase_q == PH_XFER) begin
          if (ack_dist != '0 && !ack_dist[WORD_W-1]) begin
            res_freed_d = freed;
            base_d      = base_q + WORD_W'(freed);
            head_d      = head_q + freed[SLOT_W-1:0];
            wc_d        = wc_q - freed;
          end
          close_now = 1'b1;
        end
      end
      MODE_END: begin
        src_done_d = 1'b1;
        close_now  = 1'b1;
      end
      default: ;
    endcase

    if (close_now && phase_d == PH_XFER && src_done_d && wc_d == '0) begin
      phase_d   = PH_CLOSE;
      hs_sent_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OPEN;
      hs_sent_q  <= 1'b0;
      hs_time_q  <= '0;
      now_q      <= '0;
      base_q     <= '0;
      next_q     <= '0;
      head_q     <= '0;
      wc_q       <= '0;
      src_done_q <= 1'b0;
    end else if (commit) begin
      phase_q    <= phase_d;
      hs_sent_q  <= hs_sent_d;
      hs_time_q  <= hs_time_d;
      now_q      <= now_d;
      base_q     <= base_d;
      next_q     <= next_d;
      head_q     <= head_d;
      wc_q       <= wc_d;
      src_done_q <= src_done_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (commit) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_action_q <= res_action_d;
      res_type_q   <= res_type_d;
      res_seq_q    <= res_seq_d;
      res_len_q    <= res_len_d;
      res_crc_q    <= res_crc_d;
      res_slot_q   <= res_slot_d;
      res_resend_q <= res_resend_d;
      res_freed_q  <= res_freed_d;
      res_phase_q  <= phase_d;
      res_flight_q <= wc_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign action_o       = res_action_q;
  assign pkt_type_o     = res_type_q;
  assign seq_out_o      = res_seq_q;
  assign length_out_o   = res_len_q;
  assign checksum_out_o = res_crc_q;
  assign slot_out_o     = res_slot_q;
  assign is_resend_o    = res_resend_q;
  assign freed_count_o  = res_freed_q;
  assign phase_out_o    = res_phase_q;
  assign in_flight_o    = res_flight_q;

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= CNT_W'(WINDOW_MAX))
    else $error("window count above capacity");

  a_seq_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_q - base_q) == WORD_W'(wc_q))
    else $error("sequence span disagrees with window count");

  a_open_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OPEN || phase_q == PH_DONE) |-> (wc_q == '0))
    else $error("window not empty outside transfer");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_EXEC && out_free) |=> (out_valid_o && state_q == CS_IDLE))
    else $error("finished transaction not presented");

endmodule

`default_nettype wire
